// File: rtl/bstb_pkg.sv
// Shared constants, types and status codes of the level-order BST builder.
package bstb_pkg;

  // Sizing
  localparam int unsigned MAX_NODES   = 256;
  localparam int unsigned QUEUE_DEPTH = 512;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NODE_W      = $clog2(MAX_NODES + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned IDX_W       = 8;

  // Request queue between front and back (at least 2 entries)
  localparam int unsigned IN_FIFO_DEPTH = 2;
  localparam int unsigned IN_PTR_W      = $clog2(IN_FIFO_DEPTH);
  localparam int unsigned IN_CNT_W      = $clog2(IN_FIFO_DEPTH + 1);

  localparam logic signed [KEY_W-1:0] INT_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] INT_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_PLACED  = 2'd0,
    STATUS_NO_SLOT = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // Key request as held between front and back
  typedef struct packed {
    logic signed [KEY_W-1:0] key_value;
    logic                    first_key;
  } in_item_t;

  // One open child slot
  typedef struct packed {
    logic                    has_parent;
    logic [IDX_W-1:0]        parent_index;
    logic signed [KEY_W-1:0] parent_key;
    logic signed [KEY_W-1:0] low_bound;
    logic signed [KEY_W-1:0] high_bound;
  } slot_t;

endpackage

// File: rtl/bstb_ifs.sv
// Valid/ready channel interfaces for key requests and node results.
interface bstb_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      key_value;
  logic                    first_key;

  modport source (output valid, output key_value, output first_key, input ready);
  modport sink   (input valid, input key_value, input first_key, output ready);
endinterface

interface bstb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] node_index;
  logic [7:0] parent_index;
  logic       is_root;
  logic       is_right_child;
  logic [1:0] status;

  modport source (output valid, output node_index, output parent_index, output is_root,
                  output is_right_child, output status, input ready);
  modport sink   (input valid, input node_index, input parent_index, input is_root,
                  input is_right_child, input status, output ready);
endinterface

// File: rtl/bstb_front.sv
// Front end: takes key requests and buffers them in a small queue for the back end.
module bstb_front import bstb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  bstb_in_if.sink  keys,
  output logic     item_valid,
  output in_item_t item,
  input  logic     item_pop
);

  in_item_t            entries [IN_FIFO_DEPTH];
  logic [IN_PTR_W-1:0] wr_ptr;
  logic [IN_PTR_W-1:0] rd_ptr;
  logic [IN_CNT_W-1:0] fill;
  logic                push;
  in_item_t            incoming;

  function automatic logic [IN_PTR_W-1:0] fifo_inc(input logic [IN_PTR_W-1:0] p);
    return (p == IN_PTR_W'(IN_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Capture a request, flagging a tree restart
  always_comb begin
    incoming.key_value = keys.key_value;
    incoming.first_key = keys.first_key;
  end

  assign keys.ready = (fill != IN_CNT_W'(IN_FIFO_DEPTH));
  assign push       = keys.valid && keys.ready;
  assign item_valid = (fill != '0);
  assign item       = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= fifo_inc(wr_ptr);
      end
      if (item_pop) begin
        rd_ptr <= fifo_inc(rd_ptr);
      end
      case ({push, item_pop})
        2'b10:   fill <= fill + IN_CNT_W'(1);
        2'b01:   fill <= fill - IN_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/bstb_back.sv
// Back end: slot queue in a single-port memory, placement sequencer and result register.
module bstb_back import bstb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  in_item_t   item,
  output logic       item_pop,
  bstb_out_if.source nodes
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_PUSH2,
    S_DONE
  } state_t;

  state_t                  state;
  logic signed [KEY_W-1:0] key;
  logic [QPTR_W-1:0]       head;
  logic [QPTR_W-1:0]       tail;
  logic [QCNT_W-1:0]       count;
  logic [NODE_W-1:0]       nodes_placed;

  slot_t                   slot_mem [QUEUE_DEPTH];
  slot_t                   rd_slot;
  logic                    rd_en;
  logic                    wr_en;
  logic [QPTR_W-1:0]       wr_addr;
  slot_t                   wr_data;

  logic                    cap_full;
  logic                    hit;
  logic                    out_free;

  logic [IDX_W-1:0]        res_node;
  logic [IDX_W-1:0]        res_parent;
  logic                    res_root;
  logic                    res_right;
  status_t                 res_status;

  logic                    out_valid;
  logic [IDX_W-1:0]        out_node;
  logic [IDX_W-1:0]        out_parent;
  logic                    out_root;
  logic                    out_right;
  status_t                 out_status;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign item_pop = (state == S_IDLE) && item_valid;
  assign cap_full = (nodes_placed >= NODE_W'(MAX_NODES));
  assign rd_en    = (state == S_READ) && !cap_full && (count != '0);
  assign hit      = (key >= rd_slot.low_bound) && (key <= rd_slot.high_bound);
  assign out_free = !out_valid || nodes.ready;

  // Slot writes: root slot on restart, left child on a hit, right child after
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = rd_slot;
    case (state)
      S_IDLE: begin
        if (item_pop && item.first_key) begin
          wr_en                = 1'b1;
          wr_addr              = '0;
          wr_data.has_parent   = 1'b0;
          wr_data.parent_index = '0;
          wr_data.parent_key   = '0;
          wr_data.low_bound    = INT_MIN;
          wr_data.high_bound   = INT_MAX;
        end
      end
      S_CHECK: begin
        if (hit) begin
          wr_en                = 1'b1;
          wr_data.has_parent   = 1'b1;
          wr_data.parent_index = IDX_W'(nodes_placed);
          wr_data.parent_key   = key;
          wr_data.low_bound    = rd_slot.low_bound;
          wr_data.high_bound   = key;
        end
      end
      S_PUSH2: begin
        if (count < QCNT_W'(QUEUE_DEPTH)) begin
          wr_en                = 1'b1;
          wr_data.has_parent   = 1'b1;
          wr_data.parent_index = res_node;
          wr_data.parent_key   = key;
          wr_data.low_bound    = key;
          wr_data.high_bound   = rd_slot.high_bound;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Slot memory, registered read of the queue head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_slot <= slot_mem[head];
    end
  end

  // Placement sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      nodes_placed <= '0;
      out_valid    <= 1'b0;
    end else begin
      // result taken and nothing new loaded: output register empties
      if (nodes.valid && nodes.ready && !((state == S_DONE) && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            key <= item.key_value;
            if (item.first_key) begin
              head         <= '0;
              tail         <= ptr_inc('0);
              count        <= QCNT_W'(1);
              nodes_placed <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          res_node   <= '0;
          res_parent <= '0;
          res_root   <= 1'b0;
          res_right  <= 1'b0;
          if (cap_full) begin
            res_status <= STATUS_FULL;
            state      <= S_DONE;
          end else if (count == '0) begin
            res_status <= STATUS_NO_SLOT;
            state      <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          head <= ptr_inc(head);
          if (hit) begin
            // consume the slot; the left child takes its place in the count
            res_node     <= IDX_W'(nodes_placed);
            res_parent   <= rd_slot.has_parent ? rd_slot.parent_index : '0;
            res_root     <= !rd_slot.has_parent;
            res_right    <= rd_slot.has_parent && (key >= rd_slot.parent_key);
            res_status   <= STATUS_PLACED;
            nodes_placed <= nodes_placed + 1'b1;
            tail         <= ptr_inc(tail);
            state        <= S_PUSH2;
          end else begin
            count <= count - 1'b1;
            state <= S_READ;
          end
        end
        S_PUSH2: begin
          if (count < QCNT_W'(QUEUE_DEPTH)) begin
            tail  <= ptr_inc(tail);
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_node   <= res_node;
            out_parent <= res_parent;
            out_root   <= res_root;
            out_right  <= res_right;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign nodes.valid          = out_valid;
  assign nodes.node_index     = out_node;
  assign nodes.parent_index   = out_parent;
  assign nodes.is_root        = out_root;
  assign nodes.is_right_child = out_right;
  assign nodes.status         = out_status;

endmodule

// File: rtl/bst_build_from_level_order.sv
// Level-order BST builder: one key request in, one node result out. A small input queue
// takes requests while the back end works and while a result waits to be taken. The back
// end keeps open child slots in a single-port memory with a registered read. A popped key
// is probed against the head slot (read, then compare); each slot that does not fit is
// discarded. A fitting key writes its left child slot at compare and its right child slot
// in the second push state through the one write port; its result then loads in done. A key
// rejected because the tree is full or no slot is open goes from read straight to done.
// The back end takes no new key until its result loads, and a result not yet taken holds
// the next result in done until it is. The slot memory is never cleared; a restart just
// resets head, tail and counts and writes the root slot.
module bst_build_from_level_order import bstb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bstb_in_if.sink    keys,
  bstb_out_if.source nodes
);

  logic     item_valid;
  logic     item_pop;
  in_item_t item;

  // Request intake
  bstb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .keys       (keys),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // Slot queue and placement
  bstb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .nodes      (nodes)
  );

`ifndef SYNTHESIS
  // Back end never pops an empty input queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("back end popped an empty input queue");

  // Intake backpressure only when the queue holds requests
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !keys.ready |-> item_valid)
    else $error("input stalled while queue empty");

  // A request taken into an empty queue is offered to the back end next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (keys.valid && keys.ready && !item_valid) |=> item_valid)
    else $error("accepted request not visible to back end");
`endif

endmodule
